// ===== rtl/rcfd_pkg.sv =====
// Shared types and constants for the remote-control frame decoder.
package rcfd_pkg;

    localparam int FRAME_BYTES      = 18;
    localparam int BUFFER_BYTES_DEF = 36;
    localparam int IDX_W            = $clog2(FRAME_BYTES);
    localparam int CFG_W            = 11;

    localparam logic [CFG_W-1:0] OFFSET_RESET = 11'd1024;
    localparam logic [CFG_W-1:0] LIMIT_RESET  = 11'd700;

    localparam logic [1:0] SW_DOWN = 2'd2;

    typedef enum logic
    {
        OP_BYTE = 1'b0,
        OP_IDLE = 1'b1
    } opcode_t;

    typedef enum logic
    {
        REG_CHANNEL_OFFSET = 1'b0,
        REG_ERROR_LIMIT    = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic signed [11:0] channel_0;
        logic signed [11:0] channel_1;
        logic signed [11:0] channel_2;
        logic signed [11:0] channel_3;
        logic signed [15:0] channel_4;
        logic        [3:0]  switches;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic        [15:0] mouse_buttons;
        logic        [15:0] key_bits;
        logic               frame_error;
    } frame_t;

    typedef struct packed
    {
        logic out_valid;
        logic full;
    } buf_status_t;

endpackage

// ===== rtl/rcfd_store.sv =====
// Byte counter and 18-byte frame store; flags a complete frame on idle.
module rcfd_store #(
    parameter int BUFFER_BYTES = rcfd_pkg::BUFFER_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       opcode,
    input  logic [7:0] data_byte,
    output logic [7:0] frame_bytes [rcfd_pkg::FRAME_BYTES],
    output logic       frame_go
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       store_reg  [rcfd_pkg::FRAME_BYTES];
    logic [7:0]       store_next [rcfd_pkg::FRAME_BYTES];

    always_comb
    begin
        count_next = count_reg;
        store_next = store_reg;
        if (accept)
        begin
            if (opcode == rcfd_pkg::OP_BYTE)
            begin
                if (count_reg < CNT_W'(BUFFER_BYTES))
                begin
                    count_next = count_reg + CNT_W'(1);
                    // bytes past the frame are counted only
                    if (count_reg < CNT_W'(rcfd_pkg::FRAME_BYTES))
                    begin
                        store_next[count_reg[rcfd_pkg::IDX_W-1:0]] = data_byte;
                    end
                end
            end
            else
            begin
                count_next = '0;
            end
        end
    end

    assign frame_go = accept && (opcode == rcfd_pkg::OP_IDLE)
                      && (count_reg == CNT_W'(rcfd_pkg::FRAME_BYTES));

    assign frame_bytes = store_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

endmodule

// ===== rtl/rcfd_decode.sv =====
// Field unpacking, offset removal and range check for one stored frame.
module rcfd_decode (
    input  logic [7:0]                  frame_bytes [rcfd_pkg::FRAME_BYTES],
    input  logic [rcfd_pkg::CFG_W-1:0]  channel_offset,
    input  logic [rcfd_pkg::CFG_W-1:0]  error_limit,
    output rcfd_pkg::frame_t            frame
);

    logic [10:0]        raw   [4];
    logic signed [11:0] ch    [4];
    logic [11:0]        mag   [4];
    logic [3:0]         over;
    logic [1:0]         s_left, s_right;
    logic               bad;

    always_comb
    begin
        raw[0] = {frame_bytes[1][2:0], frame_bytes[0]};
        raw[1] = {frame_bytes[2][5:0], frame_bytes[1][7:3]};
        raw[2] = {frame_bytes[4][0], frame_bytes[3], frame_bytes[2][7:6]};
        raw[3] = {frame_bytes[5][3:0], frame_bytes[4][7:1]};
        s_left  = frame_bytes[5][5:4];
        s_right = frame_bytes[5][7:6];

        for (int i = 0; i < 4; i++)
        begin
            ch[i]   = $signed({1'b0, raw[i]}) - $signed({1'b0, channel_offset});
            mag[i]  = ch[i][11] ? 12'(-ch[i]) : 12'(ch[i]);
            over[i] = mag[i] > {1'b0, error_limit};
        end

        bad = (|over) || (s_left == 2'd0) || (s_right == 2'd0);

        if (bad)
        begin
            frame             = '0;
            frame.switches    = {rcfd_pkg::SW_DOWN, rcfd_pkg::SW_DOWN};
            frame.frame_error = 1'b1;
        end
        else
        begin
            frame.channel_0     = ch[0];
            frame.channel_1     = ch[1];
            frame.channel_2     = ch[2];
            frame.channel_3     = ch[3];
            // fifth channel wraps at 16 bits
            frame.channel_4     = {frame_bytes[17], frame_bytes[16]}
                                  - {5'd0, channel_offset};
            frame.switches      = {s_right, s_left};
            frame.mouse_x       = {frame_bytes[7], frame_bytes[6]};
            frame.mouse_y       = {frame_bytes[9], frame_bytes[8]};
            frame.mouse_z       = {frame_bytes[11], frame_bytes[10]};
            frame.mouse_buttons = {frame_bytes[13], frame_bytes[12]};
            frame.key_bits      = {frame_bytes[15], frame_bytes[14]};
            frame.frame_error   = 1'b0;
        end
    end

endmodule

// ===== rtl/rcfd_out.sv =====
// Result register with one skid entry behind it.
module rcfd_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rcfd_pkg::frame_t      push_frame,
    input  logic                  out_stall,
    output rcfd_pkg::frame_t      out_frame,
    output rcfd_pkg::buf_status_t status
);

    rcfd_pkg::frame_t out_reg, out_next;
    rcfd_pkg::frame_t skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            // input is stalled while the skid entry is held
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_next       = push_frame;
            out_valid_next = push;
        end
        else if (push)
        begin
            skid_next       = push_frame;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_frame        = out_reg;
    assign status.out_valid = out_valid_reg;
    assign status.full      = skid_valid_reg;

endmodule

// ===== rtl/rc_frame_decoder.sv =====
// Top level of the remote-control 18-byte frame decoder.
//
// Takes one request per cycle while in_stall is low: a received byte (opcode
// 0) or a line-idle event (opcode 1). Bytes are stored and counted, the
// count saturating at BUFFER_BYTES; only the first 18 are kept. An idle
// event clears the count and, when exactly 18 bytes came in, yields one
// decoded frame request: the frame store feeds a single layer of decode logic
// (four 12-bit subtracts and magnitude compares) that loads the result register.
// A bad frame (stick beyond error_limit or a switch at zero) comes out with
// all fields zero, both switches at down and frame_error set. A skid entry
// behind the result register keeps input requests flowing while a result
// waits; in_stall rises only when both are full. Config writes (register 0
// channel_offset, 1 error_limit) take effect at once and belong to idle time.
module rc_frame_decoder #(
    parameter int BUFFER_BYTES = rcfd_pkg::BUFFER_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input requests
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         opcode,
    input  logic [7:0]                   data_byte,
    // result requests
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [11:0]           channel_0,
    output logic signed [11:0]           channel_1,
    output logic signed [11:0]           channel_2,
    output logic signed [11:0]           channel_3,
    output logic signed [15:0]           channel_4,
    output logic [3:0]                   switches,
    output logic signed [15:0]           mouse_x,
    output logic signed [15:0]           mouse_y,
    output logic signed [15:0]           mouse_z,
    output logic [15:0]                  mouse_buttons,
    output logic [15:0]                  key_bits,
    output logic                         frame_error,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [rcfd_pkg::CFG_W-1:0]   cfg_data
);

    logic [rcfd_pkg::CFG_W-1:0] offset_reg, offset_next;
    logic [rcfd_pkg::CFG_W-1:0] limit_reg, limit_next;

    logic                  in_accept;
    logic [7:0]            frame_bytes [rcfd_pkg::FRAME_BYTES];
    logic                  frame_go;
    rcfd_pkg::frame_t      dec_frame;
    rcfd_pkg::frame_t      out_frame;
    rcfd_pkg::buf_status_t buf_status;

    // config registers
    always_comb
    begin
        offset_next = offset_reg;
        limit_next  = limit_reg;
        if (cfg_wr_en)
        begin
            unique case (rcfd_pkg::reg_index_t'(cfg_index))
                rcfd_pkg::REG_CHANNEL_OFFSET: offset_next = cfg_data;
                rcfd_pkg::REG_ERROR_LIMIT:    limit_next  = cfg_data;
                default:                      offset_next = offset_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= rcfd_pkg::OFFSET_RESET;
            limit_reg  <= rcfd_pkg::LIMIT_RESET;
        end
        else
        begin
            offset_reg <= offset_next;
            limit_reg  <= limit_next;
        end
    end

    assign in_stall  = buf_status.full;
    assign in_accept = in_valid && !in_stall;

    rcfd_store #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .opcode     (opcode),
        .data_byte  (data_byte),
        .frame_bytes(frame_bytes),
        .frame_go   (frame_go)
    );

    // decode straight off the stored bytes; frame_go loads the result
    rcfd_decode u_decode (
        .frame_bytes   (frame_bytes),
        .channel_offset(offset_reg),
        .error_limit   (limit_reg),
        .frame         (dec_frame)
    );

    rcfd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (frame_go),
        .push_frame(dec_frame),
        .out_stall (out_stall),
        .out_frame (out_frame),
        .status    (buf_status)
    );

    assign out_valid     = buf_status.out_valid;
    assign channel_0     = out_frame.channel_0;
    assign channel_1     = out_frame.channel_1;
    assign channel_2     = out_frame.channel_2;
    assign channel_3     = out_frame.channel_3;
    assign channel_4     = out_frame.channel_4;
    assign switches      = out_frame.switches;
    assign mouse_x       = out_frame.mouse_x;
    assign mouse_y       = out_frame.mouse_y;
    assign mouse_z       = out_frame.mouse_z;
    assign mouse_buttons = out_frame.mouse_buttons;
    assign key_bits      = out_frame.key_bits;
    assign frame_error   = out_frame.frame_error;

    // skid entry only fills behind a held result
    a_stall_needs_result: assert property (
        @(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("in_stall without a pending result");

    // a new result only follows an accepted idle event
    a_result_from_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(in_valid && !in_stall && opcode))
        else $error("result without an idle event");

    // error frames carry the fixed switch pattern, a zero channel_0 and zero key_bits
    a_error_frame: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && frame_error) |-> (switches == 4'hA && channel_0 == 12'sd0
                                        && key_bits == 16'd0))
        else $error("malformed error frame");

endmodule

// ===== tb/rcfd_frame_checker.sv =====
// Frame predictor and result scoreboard for the remote-control frame decoder bench.
package rcfd_tb_pkg;

    import rcfd_pkg::*;

    class rc_frame_checker;

        logic [7:0]       frame_bytes [FRAME_BYTES];
        int unsigned      byte_count;
        int unsigned      buffer_bytes;
        logic [CFG_W-1:0] channel_offset;
        logic [CFG_W-1:0] error_limit;
        frame_t           expected_frames [$];
        int unsigned      frames_predicted;
        int unsigned      errors;

        function new(int unsigned depth);
            buffer_bytes     = depth;
            byte_count       = 0;
            channel_offset   = OFFSET_RESET;
            error_limit      = LIMIT_RESET;
            frames_predicted = 0;
            errors           = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
            if (idx == REG_CHANNEL_OFFSET)
                channel_offset = value;
            else
                error_limit = value;
        endfunction

        function int unsigned pending();
            return expected_frames.size();
        endfunction

        // Track the byte counter; an idle after exactly one frame queues a decode.
        function void absorb_request(opcode_t op, logic [7:0] data);
            logic [10:0] raw [4];
            int          ch [4];
            int          magnitude;
            logic [1:0]  sw_left;
            logic [1:0]  sw_right;
            bit          bad;
            frame_t      f;
            if (op == OP_BYTE)
            begin
                if (byte_count < buffer_bytes)
                begin
                    if (byte_count < FRAME_BYTES)
                        frame_bytes[byte_count] = data;
                    byte_count++;
                end
                return;
            end
            if (byte_count != FRAME_BYTES)
            begin
                byte_count = 0;
                return;
            end
            byte_count = 0;

            // 11-bit sticks packed LSB first across bytes 0..5
            raw[0]   = {frame_bytes[1][2:0], frame_bytes[0]};
            raw[1]   = {frame_bytes[2][5:0], frame_bytes[1][7:3]};
            raw[2]   = {frame_bytes[4][0], frame_bytes[3], frame_bytes[2][7:6]};
            raw[3]   = {frame_bytes[5][3:0], frame_bytes[4][7:1]};
            sw_left  = frame_bytes[5][5:4];
            sw_right = frame_bytes[5][7:6];

            bad = (sw_left == 2'd0) || (sw_right == 2'd0);
            for (int i = 0; i < 4; i++)
            begin
                ch[i]     = int'(raw[i]) - int'(channel_offset);
                magnitude = (ch[i] < 0) ? -ch[i] : ch[i];
                if (magnitude > int'(error_limit))
                    bad = 1'b1;
            end

            f = '0;
            if (bad)
            begin
                f.switches    = {SW_DOWN, SW_DOWN};
                f.frame_error = 1'b1;
            end
            else
            begin
                f.channel_0     = ch[0][11:0];
                f.channel_1     = ch[1][11:0];
                f.channel_2     = ch[2][11:0];
                f.channel_3     = ch[3][11:0];
                f.channel_4     = {frame_bytes[17], frame_bytes[16]} - {5'd0, channel_offset};
                f.switches      = {sw_right, sw_left};
                f.mouse_x       = {frame_bytes[7], frame_bytes[6]};
                f.mouse_y       = {frame_bytes[9], frame_bytes[8]};
                f.mouse_z       = {frame_bytes[11], frame_bytes[10]};
                f.mouse_buttons = {frame_bytes[13], frame_bytes[12]};
                f.key_bits      = {frame_bytes[15], frame_bytes[14]};
            end
            expected_frames.push_back(f);
            frames_predicted++;
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(frame_t got);
            frame_t want;
            if (expected_frames.size() == 0)
            begin
                $error("frame result with no decode pending");
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            compare_field("channel_0", 16'(want.channel_0), 16'(got.channel_0));
            compare_field("channel_1", 16'(want.channel_1), 16'(got.channel_1));
            compare_field("channel_2", 16'(want.channel_2), 16'(got.channel_2));
            compare_field("channel_3", 16'(want.channel_3), 16'(got.channel_3));
            compare_field("channel_4", want.channel_4, got.channel_4);
            compare_field("switches", 16'(want.switches), 16'(got.switches));
            compare_field("mouse_x", want.mouse_x, got.mouse_x);
            compare_field("mouse_y", want.mouse_y, got.mouse_y);
            compare_field("mouse_z", want.mouse_z, got.mouse_z);
            compare_field("mouse_buttons", want.mouse_buttons, got.mouse_buttons);
            compare_field("key_bits", want.key_bits, got.key_bits);
            compare_field("frame_error", 16'(want.frame_error), 16'(got.frame_error));
        endfunction

    endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level bench for rc_frame_decoder: byte/idle stimulus, frame checks, watchdog.
module tb_top;

    import rcfd_pkg::*;
    import rcfd_tb_pkg::*;

    localparam int N_PHASES        = 7;
    localparam int HOLD_OFF_PHASE  = 2;    // phase whose start carries the long sink hold-off
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 6;    // result register + skid entry, with margin
    localparam int PHASE_ITEMS     = 70;
    localparam int PHASE_FRAMES    = 3;
    localparam int QUIET_LIMIT     = 2000; // cycles with no request moving on either side
    localparam int STICK_MAX       = 2047;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    opcode;
    logic [7:0]              data_byte;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [11:0]      channel_0;
    logic signed [11:0]      channel_1;
    logic signed [11:0]      channel_2;
    logic signed [11:0]      channel_3;
    logic signed [15:0]      channel_4;
    logic [3:0]              switches;
    logic signed [15:0]      mouse_x;
    logic signed [15:0]      mouse_y;
    logic signed [15:0]      mouse_z;
    logic [15:0]             mouse_buttons;
    logic [15:0]             key_bits;
    logic                    frame_error;
    logic                    cfg_wr_en;
    logic                    cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    rc_frame_checker frames = new(BUFFER_BYTES_DEF);

    // sender bookkeeping
    int unsigned burst_left  = 0;
    int unsigned items_sent  = 0;
    // current register values, mirrored for shaping stick values
    int          cur_offset  = OFFSET_RESET;
    int          cur_limit   = LIMIT_RESET;
    // handshake from stimulus to the sink process
    bit          hold_off_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rc_frame_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_0     (channel_0),
        .channel_1     (channel_1),
        .channel_2     (channel_2),
        .channel_3     (channel_3),
        .channel_4     (channel_4),
        .switches      (switches),
        .mouse_x       (mouse_x),
        .mouse_y       (mouse_y),
        .mouse_z       (mouse_z),
        .mouse_buttons (mouse_buttons),
        .key_bits      (key_bits),
        .frame_error   (frame_error),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Sender side. Every task is entered and left just after a falling
    // edge; inputs only ever change there, so the DUT sees stable values
    // at the rising edge.
    // ------------------------------------------------------------------

    // One input request. Requests go out in bursts; between bursts the
    // valid line drops for a random gap (sometimes none at all).
    task automatic send_request(opcode_t op, logic [7:0] data);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(9) < 3) ? 0 : $urandom_range(8, 1);
            burst_left = $urandom_range(40, 1);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid  = 1'b1;
        opcode    = op;
        data_byte = data;
        // hold the request until an edge sees it with no stall
        do
            @(posedge clk);
        while (in_stall);
        frames.absorb_request(op, data);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_bytes(int unsigned count);
        repeat (count) send_request(OP_BYTE, 8'($urandom));
    endtask

    // Eighteen-byte frame built from four sticks and two switches. The tail
    // (mouse, buttons, keys, fifth channel) is random or a 00/FF pattern.
    task automatic send_frame(logic [10:0] r0, logic [10:0] r1, logic [10:0] r2,
                              logic [10:0] r3, logic [1:0] sl, logic [1:0] sr,
                              bit alternating_tail);
        logic [7:0] b [FRAME_BYTES];
        b[0] = r0[7:0];
        b[1] = {r1[4:0], r0[10:8]};
        b[2] = {r2[1:0], r1[10:5]};
        b[3] = r2[9:2];
        b[4] = {r3[6:0], r2[10]};
        b[5] = {sr, sl, r3[10:7]};
        for (int i = 6; i < FRAME_BYTES; i++)
            b[i] = alternating_tail ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
        for (int i = 0; i < FRAME_BYTES; i++)
            send_request(OP_BYTE, b[i]);
    endtask

    // Stick value relative to the live offset/limit: mostly in range, some
    // right on the limit, a few just past it.
    function automatic logic [10:0] pick_stick();
        int          lo;
        int          hi;
        int          v;
        int unsigned roll;
        lo   = cur_offset - cur_limit;
        hi   = cur_offset + cur_limit;
        roll = $urandom_range(99);
        if (roll < 80)
            v = $urandom_range((hi > STICK_MAX) ? STICK_MAX : hi, (lo < 0) ? 0 : lo);
        else if (roll < 93)
            v = $urandom_range(1) ? hi : lo;
        else
            v = $urandom_range(1) ? hi + 1 : lo - 1;
        if (v < 0 || v > STICK_MAX)
            v = $urandom_range(STICK_MAX);
        return v[10:0];
    endfunction

    function automatic logic [1:0] pick_switch();
        return ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(3, 1));
    endfunction

    // One random sequence. Mostly well-formed frames closed by an idle, the
    // rest noise: random frames, short and long byte runs, overflow past the
    // buffer, stray bytes after a frame and back-to-back idles.
    task automatic send_random_sequence();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
        begin
            send_frame(pick_stick(), pick_stick(), pick_stick(), pick_stick(),
                       pick_switch(), pick_switch(), $urandom_range(19) == 0);
            send_request(OP_IDLE, 8'($urandom));
        end
        else if (roll < 70)
        begin
            send_bytes(FRAME_BYTES);
            send_request(OP_IDLE, 8'($urandom));
        end
        else if (roll < 80)
        begin
            send_bytes($urandom_range(FRAME_BYTES - 1));
            send_request(OP_IDLE, 8'($urandom));
        end
        else if (roll < 88)
        begin
            // past the frame, often all the way into buffer saturation
            send_bytes($urandom_range(BUFFER_BYTES_DEF + 6, FRAME_BYTES + 1));
            send_request(OP_IDLE, 8'($urandom));
        end
        else if (roll < 94)
        begin
            send_frame(pick_stick(), pick_stick(), pick_stick(), pick_stick(),
                       pick_switch(), pick_switch(), 1'b0);
            send_bytes($urandom_range(3, 1));
            send_request(OP_IDLE, 8'($urandom));
        end
        else
        begin
            send_request(OP_IDLE, 8'($urandom));
            send_request(OP_IDLE, 8'($urandom));
        end
    endtask

    // Stop offering, wait out every pending decode, then let the pipeline
    // settle in case the last request was one that yields no frame.
    task automatic wait_drained();
        in_valid   = 1'b0;
        burst_left = 0;
        while (frames.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        frames.write_reg(idx, value);
    endtask

    // ------------------------------------------------------------------
    // Result sink: its own stall pattern, switching between free-running,
    // light and heavy back-pressure, plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned mode;
        int unsigned left;
        out_stall = 1'b0;
        left      = 0;
        mode      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                // sender keeps offering meanwhile; result reg and skid fill,
                // then in_stall must hold the input side
                hold_off_req = 1'b0;
                out_stall    = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(2);
                left = $urandom_range(60, 5);
            end
            left--;
            case (mode)
                0:       out_stall = 1'b0;
                1:       out_stall = ($urandom_range(2) == 0);
                default: out_stall = ($urandom_range(3) != 0);
            endcase
        end
    end

    // Every accepted result request goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            frames.check_result({channel_0, channel_1, channel_2, channel_3, channel_4,
                                 switches, mouse_x, mouse_y, mouse_z, mouse_buttons,
                                 key_bits, frame_error});
    end

    // Watchdog: ends the run when neither side has moved a request for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main stimulus: reset, then one phase per register setting. Register
    // writes only happen with the block drained.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned      start_items;
        int unsigned      start_frames;
        logic [CFG_W-1:0] offset_val;
        logic [CFG_W-1:0] limit_val;
        int               lo;
        int               hi;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        opcode    = OP_BYTE;
        data_byte = 8'd0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_CHANNEL_OFFSET;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            wait_drained();
            // reset values first, then the corners, then random settings
            case (phase)
                0:       begin offset_val = OFFSET_RESET; limit_val = LIMIT_RESET; end
                1:       begin offset_val = 11'd0;        limit_val = 11'd0;       end
                2:       begin offset_val = 11'd2047;     limit_val = 11'd2047;    end
                3:       begin offset_val = 11'd2047;     limit_val = 11'd0;       end
                4:       begin offset_val = 11'd0;        limit_val = 11'd2047;    end
                default:
                begin
                    offset_val = 11'($urandom_range(STICK_MAX));
                    limit_val  = 11'($urandom_range(STICK_MAX));
                end
            endcase
            write_reg(REG_CHANNEL_OFFSET, offset_val);
            write_reg(REG_ERROR_LIMIT, limit_val);
            cur_offset = offset_val;
            cur_limit  = limit_val;

            if (phase == 0)
            begin
                // idle with nothing buffered: count clears, no frame
                send_request(OP_IDLE, 8'hFF);
                // good frame with sticks right on both limits, both switch
                // extremes and a 00/FF tail through every output byte
                lo = cur_offset - cur_limit;
                hi = cur_offset + cur_limit;
                send_frame(11'(hi), 11'(lo), 11'(cur_offset), 11'(cur_offset),
                           2'd3, 2'd1, 1'b1);
                send_request(OP_IDLE, 8'h00);
            end
            if (phase == HOLD_OFF_PHASE)
                hold_off_req = 1'b1;

            start_items  = items_sent;
            start_frames = frames.frames_predicted;
            while ((items_sent - start_items) < PHASE_ITEMS ||
                   (frames.frames_predicted - start_frames) < PHASE_FRAMES)
                send_random_sequence();
        end

        wait_drained();
        if (frames.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== rc_frame_decoder.f =====
rtl/rcfd_pkg.sv
rtl/rcfd_store.sv
rtl/rcfd_decode.sv
rtl/rcfd_out.sv
rtl/rc_frame_decoder.sv
tb/rcfd_frame_checker.sv
tb/tb_top.sv
